// ===== src/lcdx_pkg.sv =====
// Package: shared types, constants and address-map tables of the LCD expander sequencer.
package lcdx_pkg;

  // Request selector codes
  localparam logic [1:0] FUNC_CMD    = 2'd0;
  localparam logic [1:0] FUNC_DATA   = 2'd1;
  localparam logic [1:0] FUNC_CURSOR = 2'd2;
  localparam logic [1:0] FUNC_NIBBLE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_BACKLIGHT = 2'd0;
  localparam logic [1:0] CFG_COLUMNS   = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  // Expander bit masks
  localparam logic [7:0] EN_MASK        = 8'h04;
  localparam logic [7:0] RS_MASK        = 8'h01;
  localparam logic [7:0] BACKLIGHT_MASK = 8'h08;
  localparam logic [7:0] NIB_MASK       = 8'hf0;
  localparam logic [7:0] DDRAM_CMD      = 8'h80;

  // Row-count values that select an address map
  localparam logic [2:0] MAP_ONE_ROW   = 3'd1;
  localparam logic [2:0] MAP_TWO_ROWS  = 3'd2;
  localparam logic [2:0] MAP_FOUR_ROWS = 3'd4;
  localparam logic [5:0] SPLIT_MIN_COLS = 6'd8;
  localparam logic [5:0] COLS_16        = 6'd16;

  // Serializer phases of the final byte
  localparam logic [2:0] LAST_PH_NIBBLE = 3'd2;
  localparam logic [2:0] LAST_PH_BYTE   = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] value;
    logic [1:0] row;
    logic [7:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic       last;
  } out_item_t;

  // Load enable and incoming valid of one pipeline stage
  typedef struct packed {
    logic load;
    logic valid;
  } stage_ctl_t;

  // Request plus partial remainder of column mod column_count
  typedef struct packed {
    in_item_t   item;
    logic [5:0] rem;
  } col_stage_t;

  typedef struct packed {
    logic [7:0] nib_hi;
    logic [7:0] nib_lo;
    logic       raw;
  } ser_item_t;

  function automatic logic [7:0] map_16x4(input logic [1:0] row);
    logic [7:0] offs;
    case (row)
      2'd0: offs = 8'h00;
      2'd1: offs = 8'h40;
      2'd2: offs = 8'h10;
      default: offs = 8'h50;
    endcase
    return offs;
  endfunction

  function automatic logic [7:0] map_20x4(input logic [1:0] row);
    logic [7:0] offs;
    case (row)
      2'd0: offs = 8'h00;
      2'd1: offs = 8'h40;
      2'd2: offs = 8'h14;
      default: offs = 8'h54;
    endcase
    return offs;
  endfunction

endpackage

// ===== src/char_lcd_expander_write_sequencer_unit.sv =====
// A request passes through registered stages B, C and D into the serializer before its first
// expander byte is on out_item. The serializer emits one byte per cycle; a byte request gives
// six expander bytes, a raw nibble three. Busy drops as soon as the entry stage can move on,
// so up to four requests overlap.
// Reset (synchronous, rst_n low) drops all in-flight transactions and restores
// backlight on, 16 columns, 2 rows.
module char_lcd_expander_write_sequencer_unit
  import lcdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  // result channel: one expander byte per strobe cycle, no back-pressure
  output logic       out_strobe,
  output out_item_t  out_item,
  // configuration write port
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  // Configuration registers; the user must write them only while the pipeline is empty (not enforced by the block)
  logic       backlight_r;
  logic [5:0] cols_r;
  logic [2:0] rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b1;
      cols_r      <= 6'd16;
      rows_r      <= 3'd2;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BACKLIGHT: backlight_r <= cfg_wdata[0];
        CFG_COLUMNS:   cols_r      <= cfg_wdata;
        CFG_ROWS:      rows_r      <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Stage control. A stage loads when it is empty or the stage after it
  // takes its contents this cycle; the serializer sets the pace at the end.
  logic       b_valid, c_valid, d_valid;
  logic       b_load, c_load, d_load;
  logic       e_take;
  stage_ctl_t b_ctl, c_ctl, d_ctl;
  col_stage_t b_in, b_stg, c_stg;
  ser_item_t  d_ser;

  assign d_load = !d_valid || e_take;
  assign c_load = !c_valid || d_load;
  assign b_load = !b_valid || c_load;
  // hold off new requests only while the entry stage is full and stuck
  assign busy   = !b_load;

  assign b_ctl = '{load: b_load, valid: start};
  assign c_ctl = '{load: c_load, valid: b_valid};
  assign d_ctl = '{load: d_load, valid: c_valid};

  assign b_in = '{item: in_item, rem: 6'd0};

  // Stage B: upper four column bits of the remainder
  lcdx_colmod_stage u_mod_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (b_ctl),
    .stg_in   (b_in),
    .dvd_bits (in_item.column[7:4]),
    .cols     (cols_r),
    .valid_o  (b_valid),
    .stg_o    (b_stg)
  );

  // Stage C: lower four column bits, remainder complete
  lcdx_colmod_stage u_mod_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (c_ctl),
    .stg_in   (b_stg),
    .dvd_bits (b_stg.item.column[3:0]),
    .cols     (cols_r),
    .valid_o  (c_valid),
    .stg_o    (c_stg)
  );

  // Stage D: address map and nibble pair
  lcdx_addr_stage u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (d_ctl),
    .stg_in  (c_stg),
    .cols    (cols_r),
    .rows    (rows_r),
    .valid_o (d_valid),
    .ser_o   (d_ser)
  );

  // Stage E: emit the expander bytes, advance on the final one
  lcdx_nibble_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d_valid),
    .ser_in     (d_ser),
    .backlight  (backlight_r),
    .take       (e_take),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== src/lcdx_colmod_stage.sv =====
// Pipeline stage: four restoring remainder steps of column mod column_count.
module lcdx_colmod_stage
  import lcdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  col_stage_t stg_in,
  input  logic [3:0] dvd_bits,
  input  logic [5:0] cols,
  output logic       valid_o,
  output col_stage_t stg_o
);

  logic       valid_r;
  col_stage_t stg_r;
  col_stage_t stg_nxt;
  logic [6:0] part;
  logic [5:0] rem;

  always_comb begin
    rem = stg_in.rem;
    part = 7'd0;
    for (int i = 3; i >= 0; i--) begin
      part = {rem, dvd_bits[i]};
      if (part >= {1'b0, cols}) begin
        part = part - {1'b0, cols};
      end
      rem = part[5:0];
    end
    stg_nxt.item = stg_in.item;
    stg_nxt.rem  = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      stg_r <= stg_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stg_o   = stg_r;

endmodule

// ===== src/lcdx_addr_stage.sv =====
// Pipeline stage: DDRAM address map, command/data byte and nibble split.
module lcdx_addr_stage
  import lcdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  col_stage_t stg_in,
  input  logic [5:0] cols,
  input  logic [2:0] rows,
  output logic       valid_o,
  output ser_item_t  ser_o
);

  logic       valid_r;
  ser_item_t  ser_r;
  ser_item_t  ser_nxt;
  logic [5:0] col;
  logic [5:0] half;
  logic [5:0] two_half;
  logic [1:0] quot;
  logic [5:0] rmd;
  logic [7:0] addr;
  logic [7:0] byte_v;
  logic [7:0] mode;

  always_comb begin
    col      = (cols == 6'd0) ? 6'd0 : stg_in.rem;
    half     = {1'b0, cols[5:1]};
    two_half = {cols[5:1], 1'b0};
    // split single row: second half sits at the second line's base
    if (col >= two_half) begin
      quot = 2'd2;
      rmd  = col - two_half;
    end else if (col >= half) begin
      quot = 2'd1;
      rmd  = col - half;
    end else begin
      quot = 2'd0;
      rmd  = col;
    end

    case (rows)
      MAP_ONE_ROW: begin
        addr = (cols > SPLIT_MIN_COLS) ? ({quot, 6'd0} + {2'b00, rmd}) : {2'b00, col};
      end
      MAP_TWO_ROWS: begin
        addr = {2'b00, col} + {stg_in.item.row, 6'd0};
      end
      MAP_FOUR_ROWS: begin
        addr = {2'b00, col} + ((cols == COLS_16) ? map_16x4(stg_in.item.row)
                                                 : map_20x4(stg_in.item.row));
      end
      default: begin
        addr = {2'b00, col};
      end
    endcase

    byte_v      = stg_in.item.value;
    mode        = 8'd0;
    ser_nxt.raw = 1'b0;
    case (stg_in.item.func)
      FUNC_CMD: begin
        byte_v = stg_in.item.value;
      end
      FUNC_DATA: begin
        mode = RS_MASK;
      end
      FUNC_CURSOR: begin
        byte_v = DDRAM_CMD | addr;
      end
      default: begin
        ser_nxt.raw = 1'b1;
      end
    endcase

    if (ser_nxt.raw) begin
      ser_nxt.nib_hi = stg_in.item.value;
      ser_nxt.nib_lo = stg_in.item.value;
    end else begin
      ser_nxt.nib_hi = (byte_v & NIB_MASK) | mode;
      ser_nxt.nib_lo = {byte_v[3:0], 4'd0} | mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ser_r <= ser_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ser_o   = ser_r;

endmodule

// ===== src/lcdx_nibble_ser.sv =====
// Output serializer: three expander bytes per nibble, one byte per cycle.
module lcdx_nibble_ser
  import lcdx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  ser_item_t ser_in,
  input  logic      backlight,
  output logic      take,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic       valid_r;
  logic [2:0] ph_r;
  logic [2:0] ph_nxt;
  ser_item_t  ser_r;
  logic       last;
  logic [7:0] nib;
  logic [7:0] bl;
  logic [7:0] exp_byte;

  always_comb begin
    last   = valid_r && (ser_r.raw ? (ph_r == LAST_PH_NIBBLE) : (ph_r == LAST_PH_BYTE));
    take   = !valid_r || last;
    ph_nxt = take ? 3'd0 : ph_r + 3'd1;
    bl     = backlight ? BACKLIGHT_MASK : 8'd0;
    nib    = (ph_r < 3'd3) ? ser_r.nib_hi : ser_r.nib_lo;
    case (ph_r)
      3'd0, 3'd3: exp_byte = nib | bl;
      3'd1, 3'd4: exp_byte = nib | EN_MASK | bl;
      3'd2, 3'd5: exp_byte = (nib & ~EN_MASK) | bl;
      default:    exp_byte = nib | bl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ph_r    <= 3'd0;
    end else begin
      ph_r <= ph_nxt;
      if (take) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ser_r <= ser_in;
    end
  end

  assign out_strobe             = valid_r;
  assign out_item.expander_byte = exp_byte;
  assign out_item.last          = last;

endmodule

// ===== tb/char_lcd_expander_write_sequencer_checker.sv =====
// Checker: tracks register writes, predicts expander byte streams and compares every result.
`timescale 1ns / 100ps
module char_lcd_expander_write_sequencer_checker
  import lcdx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_item_t   in_item,
  input  logic       out_strobe,
  input  out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata,
  output int         mismatch_count,
  output int         outstanding
);

  localparam int REPORT_MAX = 10;

  logic       backlight_on;
  logic [5:0] column_count;
  logic [2:0] row_count;
  out_item_t  expander_q[$];

  function automatic logic [7:0] ddram_address(input logic [1:0] row, input logic [7:0] column);
    int cols;
    int col;
    int half;
    int offs;
    int addr;
    cols = column_count;
    col  = (cols != 0) ? column % cols : 0;
    addr = col;
    case (row_count)
      MAP_ONE_ROW: begin
        if (cols > SPLIT_MIN_COLS) begin
          half = cols / 2;
          addr = (col % half) + (col / half) * 'h40;
        end
      end
      MAP_TWO_ROWS: begin
        addr = col + row * 'h40;
      end
      MAP_FOUR_ROWS: begin
        case (row)
          2'd0:    offs = 'h00;
          2'd1:    offs = 'h40;
          2'd2:    offs = (cols == COLS_16) ? 'h10 : 'h14;
          default: offs = (cols == COLS_16) ? 'h50 : 'h54;
        endcase
        addr = col + offs;
      end
      default: begin
        addr = col;
      end
    endcase
    return 8'(addr);
  endfunction

  function automatic void queue_nibble(input logic [7:0] nib, input logic final_nib);
    logic [7:0] bl;
    bl = backlight_on ? BACKLIGHT_MASK : 8'h00;
    expander_q.push_back('{expander_byte: nib | bl, last: 1'b0});
    expander_q.push_back('{expander_byte: nib | EN_MASK | bl, last: 1'b0});
    expander_q.push_back('{expander_byte: (nib & ~EN_MASK) | bl, last: final_nib});
  endfunction

  function automatic void queue_byte(input logic [7:0] v, input logic [7:0] mode);
    queue_nibble((v & NIB_MASK) | mode, 1'b0);
    queue_nibble({v[3:0], 4'h0} | mode, 1'b1);
  endfunction

  function automatic void predict_request(input in_item_t req);
    case (req.func)
      FUNC_CMD:    queue_byte(req.value, 8'h00);
      FUNC_DATA:   queue_byte(req.value, RS_MASK);
      FUNC_CURSOR: queue_byte(DDRAM_CMD | ddram_address(req.row, req.column), 8'h00);
      default:     queue_nibble(req.value, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      backlight_on = 1'b1;
      column_count = 6'd16;
      row_count    = 3'd2;
      expander_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BACKLIGHT: backlight_on = cfg_wdata[0];
          CFG_COLUMNS:   column_count = cfg_wdata;
          CFG_ROWS:      row_count    = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expander_q.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("unexpected result: byte %02h last %b", out_item.expander_byte,
                     out_item.last);
          mismatch_count++;
        end else begin
          want = expander_q.pop_front();
          if (out_item.expander_byte !== want.expander_byte || out_item.last !== want.last) begin
            if (mismatch_count < REPORT_MAX)
              $display("mismatch: expected byte %02h last %b, got byte %02h last %b",
                       want.expander_byte, want.last, out_item.expander_byte, out_item.last);
            mismatch_count++;
          end
        end
      end
      if (start && !busy)
        predict_request(in_item);
    end
    outstanding = expander_q.size();
  end

endmodule

// ===== tb/char_lcd_expander_write_sequencer_unit_tb.sv =====
// Testbench top: drives LCD requests and register settings, and reports the verdict.
`timescale 1ns / 100ps
module char_lcd_expander_write_sequencer_unit_tb;
  import lcdx_pkg::*;

  // Drain time after the last expected byte: pipeline latency plus margin.
  localparam int DRAIN_CYCLES = 12;
  // Far above the slowest correct run (about 250 requests).
  localparam int CYCLE_LIMIT  = 200000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  logic       busy;
  in_item_t   in_item   = '0;
  logic       out_strobe;
  out_item_t  out_item;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = CFG_BACKLIGHT;
  logic [5:0] cfg_wdata = '0;

  int mismatch_count;
  int outstanding;
  int cycle_count   = 0;
  int sent_count    = 0;
  int setting_count = 0;

  char_lcd_expander_write_sequencer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  char_lcd_expander_write_sequencer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // 10 ns clock, low phase first.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("char_lcd_expander_write_sequencer_unit_tb NOT OK");
      $finish;
    end
  end

  function automatic in_item_t lcd_request(input logic [1:0] func, input logic [7:0] value,
                                           input logic [1:0] row, input logic [7:0] column);
    in_item_t req;
    req.func   = func;
    req.value  = value;
    req.row    = row;
    req.column = column;
    return req;
  endfunction

  function automatic in_item_t random_request();
    return lcd_request(2'($urandom_range(0, 3)), 8'($urandom), 2'($urandom_range(0, 3)),
                       8'($urandom));
  endfunction

  // Hold start high with the request until the block takes it. Lower start only
  // when an idle gap follows, so back-to-back transactions keep it high.
  task automatic send_request(input in_item_t req, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  // Sample the checker's backlog on the falling edge, away from its update edge,
  // then wait out the drain time as well so the pipeline is truly empty.
  task automatic wait_drained();
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drain, then write all three registers back to back.
  task automatic write_settings(input logic bl, input logic [5:0] cols, input logic [2:0] rows);
    start <= 1'b0;
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_BACKLIGHT;
    cfg_wdata <= {5'd0, bl};
    @(posedge clk);
    cfg_index <= CFG_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_wdata <= {3'd0, rows};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    setting_count++;
  endtask

  // Random requests; burst drops all sender gaps. Halfway through, stall until
  // every expected byte has come out, so the block restarts from empty.
  task automatic run_random(input int count, input logic burst);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        start <= 1'b0;
        wait_drained();
      end
      send_request(random_request(), burst ? 0 : $urandom_range(0, 9));
    end
  endtask

  initial begin
    logic [5:0] cols;
    // Hold reset at the start, then release.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at reset settings: backlight on, 16 columns, 2 rows.
    send_request(lcd_request(FUNC_CMD,    8'h00, 2'd0, 8'd0), 0);
    send_request(lcd_request(FUNC_CMD,    8'hff, 2'd0, 8'd0), 0);
    send_request(lcd_request(FUNC_DATA,   8'h00, 2'd0, 8'd0), 2);
    send_request(lcd_request(FUNC_DATA,   8'hff, 2'd0, 8'd0), 0);
    send_request(lcd_request(FUNC_DATA,   8'ha5, 2'd3, 8'hff), 1);
    // Raw nibble: low bits pass through; the enable bit still follows the strobe.
    send_request(lcd_request(FUNC_NIBBLE, 8'hff, 2'd0, 8'd0), 0);
    send_request(lcd_request(FUNC_NIBBLE, 8'h00, 2'd0, 8'd0), 0);
    send_request(lcd_request(FUNC_NIBBLE, 8'h30, 2'd0, 8'd0), 3);
    // Cursor: origin, end of row, column wrap, widest column and row.
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd0, 8'd0), 0);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd1, 8'd15), 0);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd2, 8'd16), 0);
    send_request(lcd_request(FUNC_CURSOR, 8'hff, 2'd3, 8'd255), 0);

    // Four-row maps: the 16-column table, then the other one.
    write_settings(1'b0, 6'd16, 3'd4);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd3, 8'd5), 0);
    run_random(20, 1'b0);
    write_settings(1'b1, 6'd20, 3'd4);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd2, 8'd19), 0);
    run_random(20, 1'b1);

    // One row split in halves; the odd width reaches the third half-index.
    write_settings(1'b1, 6'd40, 3'd1);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd0, 8'd39), 0);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd1, 8'd20), 0);
    run_random(20, 1'b0);
    write_settings(1'b1, 6'd9, 3'd1);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd0, 8'd8), 0);
    run_random(15, 1'b0);
    // One row, too narrow to split.
    write_settings(1'b0, 6'd8, 3'd1);
    run_random(15, 1'b1);

    // Narrowest display, zero columns with an unmapped row count, widest field values.
    write_settings(1'b0, 6'd1, 3'd2);
    run_random(15, 1'b0);
    write_settings(1'b1, 6'd0, 3'd3);
    send_request(lcd_request(FUNC_CURSOR, 8'h00, 2'd3, 8'd200), 0);
    run_random(15, 1'b0);
    write_settings(1'b0, 6'd63, 3'd7);
    run_random(15, 1'b0);

    // Random settings, mostly within the display's normal range.
    repeat (4) begin
      cols = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(1, 40));
      write_settings(1'($urandom_range(0, 1)), cols, 3'($urandom_range(0, 7)));
      run_random(20, 1'($urandom_range(0, 1)));
    end

    // Back to reset values for a last pass.
    write_settings(1'b1, 6'd16, 3'd2);
    run_random(15, 1'b0);

    // Drop start, drain the pipeline and give the verdict.
    start <= 1'b0;
    wait_drained();
    @(negedge clk);
    $display("run covered %0d requests of all four kinds over %0d register settings",
             sent_count, setting_count);
    $display("%0d mismatches, %0d expected bytes never seen", mismatch_count, outstanding);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("char_lcd_expander_write_sequencer_unit_tb OK");
    end else begin
      $display("char_lcd_expander_write_sequencer_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
